@@ rtl/mneg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mneg_pkg;

  // field widths
  localparam int TimeW    = 48;
  localparam int NoteW    = 7;
  localparam int CountW   = 6;
  localparam int IntvW    = 16;

  // configuration port
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegEchoCount    = 1'd0;
  localparam logic [CfgIdxW-1:0] RegEchoInterval = 1'd1;

  localparam logic [CountW-1:0] EchoCountRst    = 6'd30;
  localparam logic [IntvW-1:0]  EchoIntervalRst = 16'd32;

  // velocity divider: one quotient bit per step
  localparam int DivSteps = NoteW;
  localparam int DivCntW  = 3;
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivSteps - 1);

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic emit_first;
    logic emit_next;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
  } stat_t;

endpackage

`default_nettype wire

@@ rtl/mneg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// input event channel
interface mneg_evt_if
  import mneg_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              is_note_on;
  logic [TimeW-1:0]  start_time;
  logic [NoteW-1:0]  note;
  logic [NoteW-1:0]  velocity;
  logic [TimeW-1:0]  duration;

  modport source (
    output valid, is_note_on, start_time, note, velocity, duration,
    input  ready
  );
  modport sink (
    input  valid, is_note_on, start_time, note, velocity, duration,
    output ready
  );
endinterface

// result channel
interface mneg_res_if
  import mneg_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              out_is_note_on;
  logic [TimeW-1:0]  out_start_time;
  logic [NoteW-1:0]  out_note;
  logic [NoteW-1:0]  out_velocity;
  logic [TimeW-1:0]  out_duration;
  logic              last;

  modport source (
    output valid, out_is_note_on, out_start_time, out_note, out_velocity,
           out_duration, last,
    input  ready
  );
  modport sink (
    input  valid, out_is_note_on, out_start_time, out_note, out_velocity,
           out_duration, last,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/midi_note_echo_generator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// MIDI note echo generator.
// in_evt takes one event per beat (valid/ready). A non-note-on event comes
// back unchanged as one result on out_evt. A note-on comes back as the
// original note followed by echo_count echoes, each one interval later, one
// semitone lower and with linearly decayed velocity; last marks the final
// result of every event.
// A pass-through result is valid the cycle after its input beat. A
// note-on first passes through the velocity divider (one quotient bit a cycle,
// v / (echo_count+1)), and its first result is valid after the last divide
// step; echoes then follow one per cycle while out_evt.ready is high.
// The block takes no new event until the last result of the current one is
// taken; in_evt.ready is high only when no result is pending.
// A stalled receiver simply holds the current result on out_evt.
// Reset (rst, synchronous) returns to idle and loads echo_count = 30 and
// echo_interval = 32. cfg_we/cfg_index/cfg_data write a register;
// write only while no event is in flight.
module midi_note_echo_generator
  import mneg_pkg::*;
#(
  parameter int MAX_ECHOES = 63
) (
  input  wire logic                clk,
  input  wire logic                rst,
  mneg_evt_if.sink                 in_evt,
  mneg_res_if.source               out_evt,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  mneg_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_evt.valid),
    .in_is_note_on (in_evt.is_note_on),
    .in_ready      (in_evt.ready),
    .out_valid     (out_evt.valid),
    .out_ready     (out_evt.ready),
    .cmd           (cmd),
    .stat          (stat)
  );

  // arithmetic and result register
  mneg_dpath #(
    .MAX_ECHOES (MAX_ECHOES)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_is_note_on  (in_evt.is_note_on),
    .in_start_time  (in_evt.start_time),
    .in_note        (in_evt.note),
    .in_velocity    (in_evt.velocity),
    .in_duration    (in_evt.duration),
    .out_is_note_on (out_evt.out_is_note_on),
    .out_start_time (out_evt.out_start_time),
    .out_note       (out_evt.out_note),
    .out_velocity   (out_evt.out_velocity),
    .out_duration   (out_evt.out_duration),
    .last           (out_evt.last)
  );

endmodule

`default_nettype wire

@@ rtl/mneg_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mneg_ctrl
  import mneg_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire logic  in_is_note_on,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  output cmd_t       cmd,
  input  wire stat_t stat
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]         state, state_next;
  logic [DivCntW-1:0] div_cnt, div_cnt_next;

  assign in_ready  = (state == StIdle);
  assign out_valid = (state == StEmit);

  // sequencing
  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    unique case (state)
      StIdle: begin
        if (in_valid) begin
          cmd.load     = 1'b1;
          div_cnt_next = '0;
          state_next   = in_is_note_on ? StDiv : StEmit;
        end
      end
      StDiv: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DivLast) begin
          cmd.emit_first = 1'b1;
          state_next     = StEmit;
        end
      end
      StEmit: begin
        if (out_ready) begin
          if (stat.last) begin
            state_next = StIdle;
          end else begin
            cmd.emit_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= StIdle;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/mneg_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mneg_dpath
  import mneg_pkg::*;
#(
  parameter int MAX_ECHOES = 63
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cmd_t                cmd,
  output stat_t                    stat,
  // configuration writes
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  // incoming event
  input  wire logic                in_is_note_on,
  input  wire logic [TimeW-1:0]    in_start_time,
  input  wire logic [NoteW-1:0]    in_note,
  input  wire logic [NoteW-1:0]    in_velocity,
  input  wire logic [TimeW-1:0]    in_duration,
  // current result
  output logic                     out_is_note_on,
  output logic [TimeW-1:0]         out_start_time,
  output logic [NoteW-1:0]         out_note,
  output logic [NoteW-1:0]         out_velocity,
  output logic [TimeW-1:0]         out_duration,
  output logic                     last
);

  localparam logic [CountW-1:0] MaxEchoes = CountW'(MAX_ECHOES);

  // configuration
  logic [CountW-1:0] echo_count;
  logic [IntvW-1:0]  echo_interval;

  // held event
  logic [CountW-1:0] n;
  logic [IntvW-1:0]  iv;
  logic [NoteW-1:0]  vel;
  logic [TimeW-1:0]  dur;
  logic [TimeW-1:0]  dur_cap;
  logic [CountW-1:0] idx;

  // divider: dvd ends as v / (n+1), rem as v mod (n+1)
  logic [NoteW-1:0]  dvd;
  logic [NoteW-1:0]  rem;
  logic [NoteW-1:0]  divisor;

  // running floor(j*v/(n+1)) as quotient and remainder
  logic [NoteW-1:0]  acc_q;
  logic [NoteW-1:0]  acc_r;

  logic [CountW-1:0] n_load;
  logic [NoteW:0]    rem_sh;
  logic              rem_ge;
  logic [NoteW-1:0]  rem_next;
  logic [NoteW-1:0]  r_sum;
  logic              r_wrap;
  logic [NoteW-1:0]  r_new;
  logic [NoteW-1:0]  q_new;
  logic [TimeW:0]    start_sum;
  logic [TimeW-1:0]  start_new;
  logic              echo_last;

  assign stat.last = last;

  // config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_count    <= EchoCountRst;
      echo_interval <= EchoIntervalRst;
    end else if (cfg_we) begin
      case (cfg_index)
        RegEchoCount:    echo_count    <= cfg_data[CountW-1:0];
        RegEchoInterval: echo_interval <= cfg_data[IntvW-1:0];
        default: ;
      endcase
    end
  end

  // echo count limited to the build maximum
  assign n_load = (echo_count > MaxEchoes) ? MaxEchoes : echo_count;

  // restoring divide step
  assign rem_sh   = {rem, dvd[NoteW-1]};
  assign rem_ge   = rem_sh >= {1'b0, divisor};
  assign rem_next = rem_ge ? NoteW'(rem_sh - {1'b0, divisor}) : rem_sh[NoteW-1:0];

  // next echo arithmetic
  assign r_sum     = acc_r + rem;
  assign r_wrap    = r_sum >= divisor;
  assign r_new     = r_wrap ? (r_sum - divisor) : r_sum;
  assign q_new     = acc_q + dvd + NoteW'(r_wrap);
  assign start_sum = {1'b0, out_start_time} + (TimeW + 1)'(iv);
  assign start_new = start_sum[TimeW] ? {TimeW{1'b1}} : start_sum[TimeW-1:0];
  assign echo_last = ({1'b0, idx} + 1'b1) == {1'b0, n};

  // event hold, divider and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n       <= n_load;
      iv      <= echo_interval;
      vel     <= in_velocity;
      dur     <= in_duration;
      dur_cap <= (in_duration > TimeW'(echo_interval)) ? TimeW'(echo_interval)
                                                       : in_duration;
      divisor <= NoteW'(n_load) + 1'b1;
      dvd     <= in_velocity;
      rem     <= '0;
      acc_q   <= '0;
      acc_r   <= '0;
      idx     <= '0;
      // pass-through result, replaced later for a note-on
      out_is_note_on <= in_is_note_on;
      out_start_time <= in_start_time;
      out_note       <= in_note;
      out_velocity   <= in_velocity;
      out_duration   <= in_duration;
      last           <= 1'b1;
    end
    if (cmd.div_step) begin
      dvd <= {dvd[NoteW-2:0], rem_ge};
      rem <= rem_next;
    end
    // original note
    if (cmd.emit_first) begin
      out_velocity <= vel;
      out_duration <= (n >= CountW'(2)) ? dur_cap : dur;
      last         <= (n == '0);
    end
    // one echo further on
    if (cmd.emit_next) begin
      idx            <= idx + 1'b1;
      acc_q          <= q_new;
      acc_r          <= r_new;
      out_start_time <= start_new;
      out_note       <= (out_note == '0) ? '0 : out_note - 1'b1;
      out_velocity   <= vel - q_new;
      out_duration   <= (idx == '0 && n < CountW'(3)) ? dur : dur_cap;
      last           <= echo_last;
    end
  end

endmodule

`default_nettype wire

@@ dv/echo_checker.sv @@
`timescale 1ns / 1ps

module echo_checker
  import mneg_pkg::*;
#(
  parameter int MaxEchoes = 63
) (
  input  logic                clk,
  input  logic                rst,
  mneg_evt_if                 evt,
  mneg_res_if                 res,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  fails,
  output int                  outstanding,
  output int                  beats_seen
);

  // one result beat as the block should send it
  typedef struct packed {
    logic              is_on;
    logic [TimeW-1:0]  start;
    logic [NoteW-1:0]  note;
    logic [NoteW-1:0]  vel;
    logic [TimeW-1:0]  dur;
    logic              last;
  } echo_beat_t;

  echo_beat_t       echo_train_q[$];
  logic [CountW-1:0] echo_count;
  logic [IntvW-1:0]  echo_gap;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("echo_checker: beat %0d %s got %0h want %0h", beats_seen, what, got, want);
    fails++;
  endtask

  // append one expected beat at the tail of the train
  task automatic queue_beat(input echo_beat_t b);
    echo_train_q.insert(echo_train_q.size(), b);
  endtask

  // expand a note-on into original beat and echo train, else one beat
  task automatic predict_echo_train(input logic on, input logic [TimeW-1:0] st,
                                    input logic [NoteW-1:0] nt,
                                    input logic [NoteW-1:0] ve,
                                    input logic [TimeW-1:0] du);
    echo_beat_t       b;
    logic [TimeW-1:0] capped;
    logic [63:0]      t;
    int               n;
    int               v;
    capped = (du > TimeW'(echo_gap)) ? TimeW'(echo_gap) : du;
    v = int'(ve);
    if (!on) begin
      b = '{1'b0, st, nt, ve, du, 1'b1};
      queue_beat(b);
    end else begin
      n = (int'(echo_count) > MaxEchoes) ? MaxEchoes : int'(echo_count);
      b = '{1'b1, st, nt, ve, (n >= 2) ? capped : du, n == 0};
      queue_beat(b);
      for (int j = 1; j <= n; j++) begin
        t = 64'(st) + 64'(echo_gap) * 64'(j);
        b.start = (t[63:TimeW] != '0) ? {TimeW{1'b1}} : t[TimeW-1:0];
        b.note = (int'(nt) >= j) ? NoteW'(int'(nt) - j) : '0;
        b.vel = NoteW'(v - (j * v) / (n + 1));
        if (j == 1)
          b.dur = (n >= 3) ? capped : du;
        else
          b.dur = capped;
        b.last = (j == n);
        queue_beat(b);
      end
    end
  endtask

  // compare one result beat against the oldest expectation
  task automatic check_beat();
    echo_beat_t want;
    if (echo_train_q.size() == 0) begin
      report_mismatch("unexpected beat", {res.out_start_time, res.out_note, res.out_velocity},
                      '0);
    end else begin
      want = echo_train_q.pop_front();
      if (res.out_is_note_on !== want.is_on)
        report_mismatch("out_is_note_on", 64'(res.out_is_note_on), 64'(want.is_on));
      if (res.out_start_time !== want.start)
        report_mismatch("out_start_time", 64'(res.out_start_time), 64'(want.start));
      if (res.out_note !== want.note)
        report_mismatch("out_note", 64'(res.out_note), 64'(want.note));
      if (res.out_velocity !== want.vel)
        report_mismatch("out_velocity", 64'(res.out_velocity), 64'(want.vel));
      if (res.out_duration !== want.dur)
        report_mismatch("out_duration", 64'(res.out_duration), 64'(want.dur));
      if (res.last !== want.last)
        report_mismatch("last", 64'(res.last), 64'(want.last));
    end
    beats_seen++;
  endtask

  // register shadow, prediction on input beats, checks on result beats
  always @(posedge clk) begin
    if (rst) begin
      echo_count <= EchoCountRst;
      echo_gap <= EchoIntervalRst;
      fails = 0;
      beats_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegEchoCount: echo_count <= cfg_data[CountW-1:0];
          RegEchoInterval: echo_gap <= cfg_data[IntvW-1:0];
          default: ;
        endcase
      end
      if (evt.valid && evt.ready)
        predict_echo_train(evt.is_note_on, evt.start_time, evt.note, evt.velocity,
                           evt.duration);
      if (res.valid && res.ready)
        check_beat();
    end
    outstanding <= echo_train_q.size();
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import mneg_pkg::*;

  localparam int MaxEchoes = 63;
  localparam logic [TimeW-1:0] TickMax = {TimeW{1'b1}};

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                steady;
  logic                choke;
  logic [IntvW-1:0]    cur_gap;
  int                  fails;
  int                  outstanding;
  int                  beats_seen;
  int                  events_sent;
  int                  settings_used;

  mneg_evt_if evt_ch ();
  mneg_res_if res_ch ();

  midi_note_echo_generator #(
    .MAX_ECHOES(MaxEchoes)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_evt(evt_ch),
    .out_evt(res_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  echo_checker #(
    .MaxEchoes(MaxEchoes)
  ) train_check (
    .clk(clk),
    .rst(rst),
    .evt(evt_ch),
    .res(res_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fails(fails),
    .outstanding(outstanding),
    .beats_seen(beats_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // result side: random back-pressure, one long hold-off when asked
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (choke) begin
        choke = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      res_ch.ready <= steady || ($urandom_range(99) >= 21);
    end
  end

  function automatic logic [TimeW-1:0] rand_ticks();
    return TimeW'({$urandom(), $urandom()});
  endfunction

  // offer one event beat and hold it until taken
  task automatic send_event(input logic on, input logic [TimeW-1:0] st,
                            input logic [NoteW-1:0] nt, input logic [NoteW-1:0] ve,
                            input logic [TimeW-1:0] du);
    int gap;
    gap = 0;
    while (!steady && $urandom_range(99) < 21) gap++;
    if (gap > 0) begin
      evt_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    evt_ch.valid <= 1'b1;
    evt_ch.is_note_on <= on;
    evt_ch.start_time <= st;
    evt_ch.note <= nt;
    evt_ch.velocity <= ve;
    evt_ch.duration <= du;
    do @(posedge clk); while (!evt_ch.ready);
    events_sent++;
  endtask

  task automatic send_random();
    logic             on;
    logic [TimeW-1:0] st;
    logic [TimeW-1:0] du;
    logic [NoteW-1:0] nt;
    logic [NoteW-1:0] ve;
    on = ($urandom_range(99) < 80);
    case ($urandom_range(3))
      0: st = TickMax - TimeW'($urandom_range(4200000));
      1: st = TimeW'($urandom_range(100000));
      default: st = rand_ticks();
    endcase
    case ($urandom_range(4))
      0: du = TimeW'($urandom_range(70000));
      1: du = rand_ticks();
      2: du = $urandom_range(1) ? TickMax : '0;
      3: du = TimeW'(cur_gap) + TimeW'($urandom_range(1));
      default: du = TimeW'($urandom_range(300));
    endcase
    nt = ($urandom_range(9) == 0) ? NoteW'($urandom_range(3)) : NoteW'($urandom_range(127));
    ve = ($urandom_range(9) == 0) ? NoteW'(127 - $urandom_range(1)) :
                                    NoteW'($urandom_range(127));
    send_event(on, st, nt, ve, du);
  endtask

  // let every expected beat drain, then idle before returning
  task automatic wait_idle();
    int spin;
    evt_ch.valid <= 1'b0;
    spin = 0;
    do begin
      @(posedge clk);
      spin++;
    end while (outstanding != 0 && spin < 100000);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [CountW-1:0] cnt, input logic [IntvW-1:0] iv);
    wait_idle();
    set_reg(RegEchoCount, CfgDataW'(cnt));
    set_reg(RegEchoInterval, CfgDataW'(iv));
    cur_gap = iv;
    settings_used++;
  endtask

  initial begin
    logic [CountW-1:0] cnt;
    logic [IntvW-1:0]  iv;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= RegEchoCount;
    cfg_data <= '0;
    evt_ch.valid <= 1'b0;
    evt_ch.is_note_on <= 1'b0;
    evt_ch.start_time <= '0;
    evt_ch.note <= '0;
    evt_ch.velocity <= '0;
    evt_ch.duration <= '0;
    steady = 1'b0;
    choke = 1'b0;
    cur_gap = EchoIntervalRst;
    events_sent = 0;
    settings_used = 1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: pass-through extremes, note clamp, saturation, cap edges
    wait_idle();
    send_event(1'b0, '0, '0, '0, '0);
    send_event(1'b0, TickMax, 7'd127, 7'd127, TickMax);
    send_event(1'b1, '0, '0, 7'd127, TickMax);
    send_event(1'b1, TickMax, 7'd127, '0, '0);
    send_event(1'b1, 48'd1000, 7'd60, 7'd100, 48'd32);
    send_event(1'b1, 48'd5, 7'd10, 7'd1, 48'd31);
    send_event(1'b1, 48'd77, 7'd29, 7'd64, 48'd33);

    // no echoes at all
    configure(6'd0, 16'd1);
    send_event(1'b1, TickMax - 48'd1, 7'd64, 7'd100, TickMax);
    send_event(1'b0, 48'd12, 7'd3, 7'd9, 48'd400);
    send_event(1'b1, 48'd0, 7'd0, 7'd127, 48'd2);

    // widest train and longest spacing
    configure(6'd63, 16'hFFFF);
    send_event(1'b1, TickMax - 48'd1000, 7'd127, 7'd127, TickMax);
    send_event(1'b1, '0, 7'd30, 7'd63, 48'd65534);
    send_event(1'b1, rand_ticks(), 7'd90, 7'd127, 48'd65536);

    // zero spacing: the one echo at the same tick as the original, durations uncapped
    configure(6'd1, 16'd0);
    send_event(1'b1, 48'd500, 7'd0, 7'd127, 48'd5);
    send_event(1'b1, TickMax, 7'd1, 7'd1, 48'd0);

    // duration cap thresholds for the original and the first echo
    configure(6'd2, 16'd40);
    send_event(1'b1, 48'd9, 7'd50, 7'd99, 48'd100);
    send_event(1'b1, 48'd9, 7'd50, 7'd99, 48'd10);
    configure(6'd3, 16'd40);
    send_event(1'b1, 48'd9, 7'd2, 7'd120, 48'd100);
    send_event(1'b1, 48'd9, 7'd2, 7'd120, 48'd39);
    configure(6'd4, 16'd40);
    send_event(1'b1, 48'd9, 7'd70, 7'd127, 48'd1000);

    // random phases, each under its own register setting
    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(3))
        0: cnt = CountW'($urandom_range(3));
        1: cnt = CountW'($urandom_range(15, 4));
        2: cnt = CountW'($urandom_range(63, 16));
        default: cnt = 6'd63;
      endcase
      case ($urandom_range(4))
        0: iv = IntvW'($urandom_range(1));
        1: iv = IntvW'($urandom_range(300, 1));
        2: iv = 16'hFFFF;
        default: iv = IntvW'($urandom_range(65535));
      endcase
      configure(cnt, iv);
      steady = (p == 3);
      if (p == 6) choke = 1'b1;
      repeat (48) send_random();
    end

    wait_idle();
    $display("summary: %0d events over %0d register settings, %0d result beats checked",
             events_sent, settings_used, beats_seen);
    $display("summary: pass-through, no-echo, zero-spacing, saturation and long hold-off runs");
    if (fails == 0 && outstanding == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
